@@ design/ssh_pkg.sv @@
// Shared types and constants for the stream sequence health monitor.
// No dependencies; imported by every module of the block.
package ssh_pkg;

  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned NUM_W   = 32;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned TDATA_W = 136;

  localparam logic [2:0]  STREAMS_RESET = 3'd1;
  localparam logic [2:0]  COLOR_NONE    = 3'd4;

  typedef enum logic [2:0] {
    REG_STREAMS_IN_USE = 3'd0,
    REG_WINDOW         = 3'd1,
    REG_REQUIRE        = 3'd2,
    REG_COLOR_REUSE    = 3'd3,
    REG_COLOR_SLOT     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]       streams_in_use;
    logic [NUM_W-1:0] window_len;
    logic             require_complete;
    logic             allow_color_reuse;
    logic [2:0]       color_slot;
  } cfg_t;

endpackage

@@ design/ssh_cfg.sv @@
// Configuration register file with an APB-style access port.
// Depends on ssh_pkg for the register map and the cfg_t bundle.
module ssh_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ssh_pkg::ADDR_W-1:0] paddr,
  input  logic [ssh_pkg::DATA_W-1:0] pwdata,
  output logic [ssh_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output ssh_pkg::cfg_t              cfg
);
  import ssh_pkg::*;

  logic     wr_en;
  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.streams_in_use    <= STREAMS_RESET;
      cfg.window_len        <= '0;
      cfg.require_complete  <= 1'b0;
      cfg.allow_color_reuse <= 1'b0;
      cfg.color_slot        <= COLOR_NONE;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_STREAMS_IN_USE: cfg.streams_in_use    <= pwdata[2:0];
        REG_WINDOW:         cfg.window_len        <= pwdata[NUM_W-1:0];
        REG_REQUIRE:        cfg.require_complete  <= pwdata[0];
        REG_COLOR_REUSE:    cfg.allow_color_reuse <= pwdata[0];
        REG_COLOR_SLOT:     cfg.color_slot        <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_STREAMS_IN_USE: prdata = DATA_W'(cfg.streams_in_use);
      REG_WINDOW:         prdata = DATA_W'(cfg.window_len);
      REG_REQUIRE:        prdata = DATA_W'(cfg.require_complete);
      REG_COLOR_REUSE:    prdata = DATA_W'(cfg.allow_color_reuse);
      REG_COLOR_SLOT:     prdata = DATA_W'(cfg.color_slot);
      default:            prdata = '0;
    endcase
  end

endmodule

@@ design/ssh_slot_health.sv @@
// Health verdict for one stream slot from its counters and the configuration.
// Depends on ssh_pkg for cfg_t.
module ssh_slot_health #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic [COUNT_BITS-1:0] seen,
  input  logic [COUNT_BITS-1:0] dup,
  input  logic [COUNT_BITS-1:0] reorder,
  input  logic [COUNT_BITS-1:0] gap,
  input  logic                  is_color,
  input  ssh_pkg::cfg_t         cfg,
  output logic                  healthy
);
  import ssh_pkg::*;

  localparam int unsigned PW = (COUNT_BITS + 5 > NUM_W) ? COUNT_BITS + 5 : NUM_W;

  logic [PW-1:0] seen_x;
  logic [PW-1:0] dup_x;
  logic [PW-1:0] dup20;
  logic [PW-1:0] win_x;
  logic          seen_ok;
  logic          complete_ok;
  logic          dup_ok;

  assign seen_x = PW'(seen);
  assign dup_x  = PW'(dup);
  assign win_x  = PW'(cfg.window_len);
  // dup <= floor(w/20) is the same as 20*dup <= w
  assign dup20  = (dup_x << 4) + (dup_x << 2);

  assign seen_ok     = seen_x >= PW'(2);
  assign complete_ok = !cfg.require_complete || (seen_x == win_x);
  assign dup_ok      = (dup_x == '0) ||
                       (cfg.allow_color_reuse && is_color &&
                        ((dup_x == PW'(1)) || (dup20 <= win_x)));

  assign healthy = seen_ok && complete_ok && dup_ok && (gap == '0) && (reorder == '0);

endmodule

@@ design/stream_sequence_health_monitor.sv @@
// Stream sequence health monitor: per-slot sequence checking and health report.
// An accepted word is held in the input register; its result is then written to the result register.
// Throughput: one word per cycle unless m_tready stalls, set by the single input-to-result update pass.
// Reset (rst, synchronous): counters, last numbers, valid flags and config return to reset values.
// Depends on ssh_pkg, ssh_cfg and ssh_slot_health.
module stream_sequence_health_monitor #(
  parameter int unsigned NUM_STREAMS = 4,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssh_pkg::ADDR_W-1:0]  paddr,
  input  logic [ssh_pkg::DATA_W-1:0]  pwdata,
  output logic [ssh_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [ssh_pkg::NUM_W-1:0]   s_tdata,  // seq_number
  input  logic [ssh_pkg::SLOT_W-1:0]  s_tuser,  // stream_slot
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // seen_count, duplicate_count, reorder_count, gap_count, stream_healthy,
  // all_healthy, zero fill
  output logic [ssh_pkg::TDATA_W-1:0] m_tdata,
  output logic                        m_tuser   // unknown_stream
);
  import ssh_pkg::*;

  localparam int unsigned IDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int unsigned SUM_W = ((COUNT_BITS > NUM_W) ? COUNT_BITS : NUM_W) + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [4:0] NS5 = 5'(NUM_STREAMS);

  cfg_t cfg;

  ssh_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  logic              in_valid;
  logic [SLOT_W-1:0] in_slot;
  logic [NUM_W-1:0]  in_num;
  logic              s_accept;
  logic              advance;

  // per-slot state
  logic                  has_previous    [NUM_STREAMS];
  logic [NUM_W-1:0]      previous_number [NUM_STREAMS];
  logic [COUNT_BITS-1:0] seen_store      [NUM_STREAMS];
  logic [COUNT_BITS-1:0] duplicate_store [NUM_STREAMS];
  logic [COUNT_BITS-1:0] reorder_store   [NUM_STREAMS];
  logic [COUNT_BITS-1:0] gap_store       [NUM_STREAMS];

  logic [4:0]            n_active;
  logic                  known;
  logic                  upd;
  logic [IDX_W-1:0]      idx;
  logic [NUM_W-1:0]      last;
  logic                  prev_ok;
  logic                  is_dup;
  logic                  is_reo;
  logic                  is_gap;
  logic [NUM_W-1:0]      gap_amt;
  logic [SUM_W-1:0]      gap_sum;
  logic [COUNT_BITS-1:0] seen_next;
  logic [COUNT_BITS-1:0] dup_next;
  logic [COUNT_BITS-1:0] reorder_next;
  logic [COUNT_BITS-1:0] gap_next;

  logic [COUNT_BITS-1:0] v_seen    [NUM_STREAMS];
  logic [COUNT_BITS-1:0] v_dup     [NUM_STREAMS];
  logic [COUNT_BITS-1:0] v_reorder [NUM_STREAMS];
  logic [COUNT_BITS-1:0] v_gap     [NUM_STREAMS];
  logic [NUM_STREAMS-1:0] slot_ok;
  logic [NUM_STREAMS-1:0] slot_used;
  logic                   all_ok;

  function automatic logic [OUT_W-1:0] clip_out(input logic [COUNT_BITS-1:0] v);
    logic [SUM_W-1:0] ext;
    ext = SUM_W'(v);
    return (ext > SUM_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : ext[OUT_W-1:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == CNT_MAX) ? c : c + COUNT_BITS'(1);
  endfunction

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_slot <= s_tuser;
      in_num  <= s_tdata;
    end
  end

  // decode and update
  assign n_active = ({2'b0, cfg.streams_in_use} > NS5) ? NS5 : {2'b0, cfg.streams_in_use};
  assign known    = {2'b0, in_slot} < n_active;
  assign upd      = advance && known;
  assign idx      = IDX_W'(in_slot);

  assign last    = previous_number[idx];
  assign prev_ok = has_previous[idx];
  assign is_dup  = prev_ok && (in_num == last);
  assign is_reo  = prev_ok && (in_num < last);
  assign is_gap  = prev_ok && ({1'b0, in_num} > ({1'b0, last} + (NUM_W + 1)'(1)));
  assign gap_amt = in_num - last - NUM_W'(1);
  assign gap_sum = SUM_W'(gap_store[idx]) + SUM_W'(gap_amt);

  always_comb begin
    seen_next    = sat_inc(seen_store[idx]);
    dup_next     = is_dup ? sat_inc(duplicate_store[idx]) : duplicate_store[idx];
    reorder_next = is_reo ? sat_inc(reorder_store[idx]) : reorder_store[idx];
    gap_next     = gap_store[idx];
    if (is_gap) begin
      gap_next = (gap_sum > SUM_W'(CNT_MAX)) ? CNT_MAX : gap_sum[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STREAMS; i++) begin
        has_previous[i]    <= 1'b0;
        previous_number[i] <= '0;
        seen_store[i]      <= '0;
        duplicate_store[i] <= '0;
        reorder_store[i]   <= '0;
        gap_store[i]       <= '0;
      end
    end else if (upd) begin
      has_previous[idx]    <= 1'b1;
      previous_number[idx] <= in_num;
      seen_store[idx]      <= seen_next;
      duplicate_store[idx] <= dup_next;
      reorder_store[idx]   <= reorder_next;
      gap_store[idx]       <= gap_next;
    end
  end

  // health of every slot as it stands after this word
  for (genvar g = 0; g < NUM_STREAMS; g++) begin : g_slot
    logic hit;
    assign hit          = known && (idx == IDX_W'(g));
    assign v_seen[g]    = hit ? seen_next    : seen_store[g];
    assign v_dup[g]     = hit ? dup_next     : duplicate_store[g];
    assign v_reorder[g] = hit ? reorder_next : reorder_store[g];
    assign v_gap[g]     = hit ? gap_next     : gap_store[g];
    assign slot_used[g] = 5'(g) < n_active;

    ssh_slot_health #(.COUNT_BITS(COUNT_BITS)) u_health (
      .seen     (v_seen[g]),
      .dup      (v_dup[g]),
      .reorder  (v_reorder[g]),
      .gap      (v_gap[g]),
      .is_color ({2'b0, cfg.color_slot} == 5'(g)),
      .cfg      (cfg),
      .healthy  (slot_ok[g])
    );
  end

  assign all_ok = &(slot_ok | ~slot_used);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tuser <= !known;
      if (known) begin
        m_tdata <= {6'b0, all_ok, slot_ok[idx], clip_out(gap_next), clip_out(reorder_next),
                    clip_out(dup_next), clip_out(seen_next)};
      end else begin
        m_tdata <= {6'b0, all_ok, 129'b0};
      end
    end
  end

  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[128:0] == '0)
    else $error("unknown slot result carries counts");

  a_healthy_seen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[128] |-> m_tdata[31:1] != '0)
    else $error("healthy stream with fewer than two frames");

  a_healthy_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[128] |-> m_tdata[127:64] == '0)
    else $error("healthy stream with gaps or reorders");

  a_all_implies_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser && m_tdata[129] |-> m_tdata[128])
    else $error("all streams healthy but reported stream is not");

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for stream_sequence_health_monitor: frames in, per-slot counters out.
// A scoreboard class predicts every result word; needs only ssh_pkg and the block's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ssh_pkg::*;

  localparam int SLOTS = 4;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [NUM_W-1:0]  number;
  } frame_t;

  typedef struct packed {
    logic               unknown;
    logic [OUT_W-1:0]   seen;
    logic [OUT_W-1:0]   dups;
    logic [OUT_W-1:0]   reorders;
    logic [OUT_W-1:0]   gaps;
    logic               stream_ok;
    logic               all_ok;
    logic [TDATA_W-131:0] fill;
  } health_word_t;

  class health_scoreboard;
    logic [2:0]       streams_in_use;
    logic [NUM_W-1:0] window;
    logic             require_complete;
    logic             allow_reuse;
    logic [2:0]       color_slot;
    logic             has_prev[SLOTS];
    logic [NUM_W-1:0] prev_num[SLOTS];
    logic [OUT_W-1:0] seen[SLOTS];
    logic [OUT_W-1:0] dups[SLOTS];
    logic [OUT_W-1:0] reorders[SLOTS];
    logic [OUT_W-1:0] gaps[SLOTS];
    health_word_t     expected_q[$];
    int unsigned      errors;

    function new();
      streams_in_use   = STREAMS_RESET;
      window           = '0;
      require_complete = 1'b0;
      allow_reuse      = 1'b0;
      color_slot       = COLOR_NONE;
      errors           = 0;
      for (int i = 0; i < SLOTS; i++) begin
        has_prev[i] = 1'b0;
        prev_num[i] = '0;
        seen[i]     = '0;
        dups[i]     = '0;
        reorders[i] = '0;
        gaps[i]     = '0;
      end
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_STREAMS_IN_USE: streams_in_use = v[2:0];
        REG_WINDOW:         window = v;
        REG_REQUIRE:        require_complete = v[0];
        REG_COLOR_REUSE:    allow_reuse = v[0];
        REG_COLOR_SLOT:     color_slot = v[2:0];
        default: ;
      endcase
    endfunction

    function int active_slots();
      return (streams_in_use > SLOTS) ? SLOTS : int'(streams_in_use);
    endfunction

    function logic [OUT_W-1:0] allowance(int s);
      logic [OUT_W-1:0] a;
      a = '0;
      if (allow_reuse && s == int'(color_slot)) begin
        a = window / 20;
        if (a < 1) a = 1;
      end
      return a;
    endfunction

    function logic [OUT_W-1:0] sat_add(logic [OUT_W-1:0] c, logic [OUT_W-1:0] add);
      logic [OUT_W:0] sum;
      sum = {1'b0, c} + {1'b0, add};
      return sum[OUT_W] ? {OUT_W{1'b1}} : sum[OUT_W-1:0];
    endfunction

    function logic healthy(int s);
      if (seen[s] < 2) return 1'b0;
      if (require_complete && seen[s] != window) return 1'b0;
      if (dups[s] > allowance(s)) return 1'b0;
      if (gaps[s] != 0 || reorders[s] != 0) return 1'b0;
      return 1'b1;
    endfunction

    function void note_frame(frame_t f);
      health_word_t w;
      int n;
      int s;
      logic all;
      n = active_slots();
      s = int'(f.slot);
      all = 1'b1;
      w = '0;
      if (s < n) begin
        if (has_prev[s]) begin
          if (f.number == prev_num[s])
            dups[s] = sat_add(dups[s], 1);
          else if (f.number < prev_num[s])
            reorders[s] = sat_add(reorders[s], 1);
          else if (f.number - prev_num[s] > 1)
            gaps[s] = sat_add(gaps[s], f.number - prev_num[s] - 1);
        end
        has_prev[s] = 1'b1;
        prev_num[s] = f.number;
        seen[s]     = sat_add(seen[s], 1);
      end
      for (int i = 0; i < n; i++)
        if (!healthy(i)) all = 1'b0;
      if (s < n) begin
        w.seen      = seen[s];
        w.dups      = dups[s];
        w.reorders  = reorders[s];
        w.gaps      = gaps[s];
        w.stream_ok = healthy(s);
      end else begin
        w.unknown = 1'b1;
      end
      w.all_ok = all;
      expected_q.insert(expected_q.size(), w);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(health_word_t got);
      health_word_t want;
      if (expected_q.size() == 0) begin
        report("word with nothing expected", got.seen, '0);
      end else begin
        want = expected_q.pop_front();
        if (got.unknown !== want.unknown)
          report("unknown_stream", 32'(got.unknown), 32'(want.unknown));
        if (got.seen !== want.seen) report("seen_count", got.seen, want.seen);
        if (got.dups !== want.dups) report("duplicate_count", got.dups, want.dups);
        if (got.reorders !== want.reorders)
          report("reorder_count", got.reorders, want.reorders);
        if (got.gaps !== want.gaps) report("gap_count", got.gaps, want.gaps);
        if (got.stream_ok !== want.stream_ok)
          report("stream_healthy", 32'(got.stream_ok), 32'(want.stream_ok));
        if (got.all_ok !== want.all_ok)
          report("all_healthy", 32'(got.all_ok), 32'(want.all_ok));
        if (got.fill !== want.fill) report("tdata fill", 32'(got.fill), 32'(want.fill));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [NUM_W-1:0]     s_tdata;   // seq_number
  logic [SLOT_W-1:0]    s_tuser;   // stream_slot
  logic                 m_tvalid;
  logic                 m_tready;
  // seen_count, duplicate_count, reorder_count, gap_count, stream_healthy,
  // all_healthy, zero fill
  logic [TDATA_W-1:0]   m_tdata;
  logic                 m_tuser;   // unknown_stream

  health_scoreboard sb;
  logic hold_req;
  logic quiet;

  stream_sequence_health_monitor DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  // result side: random stalls, one long hold-off on request, none when quiet
  initial begin
    int stall_left;
    logic hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_done = 1'b1;
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(0, 15);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    health_word_t got;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.unknown   = m_tuser;
        got.seen      = m_tdata[31:0];
        got.dups      = m_tdata[63:32];
        got.reorders  = m_tdata[95:64];
        got.gaps      = m_tdata[127:96];
        got.stream_ok = m_tdata[128];
        got.all_ok    = m_tdata[129];
        got.fill      = m_tdata[TDATA_W-1:130];
        sb.check_result(got);
      end
    end
  end

  task write_reg(reg_idx_t idx, logic [31:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task configure(logic [2:0] n, logic [31:0] win, logic req, logic reuse, logic [2:0] color);
    write_reg(REG_STREAMS_IN_USE, {29'd0, n});
    write_reg(REG_WINDOW, win);
    write_reg(REG_REQUIRE, {31'd0, req});
    write_reg(REG_COLOR_REUSE, {31'd0, reuse});
    write_reg(REG_COLOR_SLOT, {29'd0, color});
  endtask

  task send_frame(logic [2:0] slot, logic [31:0] num);
    frame_t f;
    f.slot   = slot;
    f.number = num;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= slot;
    s_tdata  <= num;
    do @(posedge clk); while (!s_tready);
    sb.note_frame(f);
  endtask

  task idle_sender(int k);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (k - 1) @(negedge clk);
  endtask

  // hold until every expected word is back, then let the pipeline drain
  task wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function logic [31:0] pick_window();
    case ($urandom_range(0, 6))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'd19;
      3: return 32'd20;
      4: return $urandom;
      5: return sb.seen[0] + $urandom_range(5, 40);
      default: return $urandom_range(21, 400);
    endcase
  endfunction

  // mostly in-order numbers; anomalies on the dirty slot or in dirty phases
  function logic [31:0] pick_number(int slot, logic dirty);
    logic [31:0] last;
    int r;
    if (slot >= SLOTS) return $urandom;
    if (!sb.has_prev[slot]) return $urandom_range(32'hEFFF_FFFF, 0);
    last = sb.prev_num[slot];
    r = $urandom_range(0, 99);
    if (dirty || slot == SLOTS - 1) begin
      if (r < 4) return last;
      if (r < 7) return (last == 0) ? last : $urandom_range(last - 1, 0);
      if (r < 10) return (last < 32'hFFFF_0000) ? last + $urandom_range(1000, 2) : $urandom;
    end
    if (sb.allow_reuse && slot == int'(sb.color_slot) && r < 15 &&
        sb.dups[slot] < sb.allowance(slot))
      return last;
    return last + 1;
  endfunction

  task run_phase(int target, logic dirty, logic no_gaps);
    int known;
    int total;
    int n;
    int slot;
    logic [31:0] num;
    known = 0;
    total = 0;
    while (known < target && total < 3 * target + 10) begin
      n = sb.active_slots();
      if (n == 0 || $urandom_range(0, 9) == 0)
        slot = $urandom_range(7, n);
      else
        slot = $urandom_range(n - 1, 0);
      num = pick_number(slot, dirty);
      if (!no_gaps && $urandom_range(0, 7) == 0) idle_sender($urandom_range(1, 16));
      send_frame(slot[2:0], num);
      total++;
      if (slot < n) known++;
    end
  endtask

  logic [2:0]  d_slot[18] = '{3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3,
                               3'd3, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd2, 3'd1};
  logic [31:0] d_num[18]  = '{32'd1, 32'd2, 32'h8000_0000, 32'h8000_0001, 32'd5, 32'd6,
                               32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 32'd0, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
                               32'd3, 32'd7, 32'h8000_0002};

  initial begin
    sb       = new();
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    hold_req = 1'b0;
    quiet    = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: one slot in use
    send_frame(3'd0, 32'd0);
    send_frame(3'd1, 32'd7);
    wait_idle();

    configure(3'd4, 32'd40, 1'b0, 1'b1, 3'd0);
    for (int i = 0; i < 18; i++) send_frame(d_slot[i], d_num[i]);
    wait_idle();

    for (int p = 0; p < 13; p++) begin
      case (p)
        0: configure(3'd3, 32'd0, 1'b0, 1'b0, COLOR_NONE);
        1: configure(3'd3, sb.seen[0] + $urandom_range(35, 10), 1'b1, 1'b1, 3'd0);
        2: configure(3'd2, 32'hFFFF_FFFF, 1'b0, 1'b1, 3'd1);
        3: configure(3'd0, $urandom, 1'($urandom_range(1, 0)), 1'b1, 3'd0);
        4: configure(3'd7, $urandom_range(200, 20), 1'b0, 1'b1, 3'd7);
        default: configure(3'($urandom_range(7, 1)), pick_window(),
                           1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                           3'($urandom_range(7, 0)));
      endcase
      if (p == 5) hold_req = 1'b1;
      if (p == 12) quiet = 1'b1;
      run_phase((p == 3) ? 5 : 110, p >= 7, p == 12);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.report("words still expected", 32'(sb.pending()), '0);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ files.f @@
design/ssh_pkg.sv
design/ssh_cfg.sv
design/ssh_slot_health.sv
design/stream_sequence_health_monitor.sv
bench/testbench.sv
